FILE: hdl/smc_pkg.sv
// Shared constants, types and helpers for the subscription match counter.
package smc_pkg;
  localparam int MaxSubs    = 64;
  localparam int MaxCons    = 8;
  localparam int MaxPairs   = 16;
  localparam int AttrBits   = 8;
  localparam int ValueBits  = 32;
  localparam int SubBits    = 6;
  localparam int SlotBits   = 3;
  localparam int CntBits    = 4;
  localparam int ActBits    = 7;
  localparam int PairBits   = 4;
  localparam int FillBits   = 5;
  localparam int ConsDepth  = MaxSubs * MaxCons;
  localparam int ConsBits   = 9;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_COUNT = 2'd1;
  localparam logic [1:0] REQ_PAIR  = 2'd2;

  localparam logic [1:0] KIND_EQ = 2'd0;
  localparam logic [1:0] KIND_LE = 2'd1;
  localparam logic [1:0] KIND_GE = 2'd2;
  localparam logic [1:0] KIND_IN = 2'd3;

  typedef struct packed {
    logic [AttrBits-1:0]  attr;
    logic [1:0]           kind;
    logic [ValueBits-1:0] low;
    logic [ValueBits-1:0] high;
  } cons_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [SubBits-1:0]   sub_index;
    logic [SlotBits-1:0]  slot_index;
    logic [CntBits-1:0]   constraint_count;
    logic [AttrBits-1:0]  attribute;
    logic [1:0]           constraint_kind;
    logic [ValueBits-1:0] bound_low;
    logic [ValueBits-1:0] bound_high;
    logic [ValueBits-1:0] pair_value;
    logic                 last_pair;
  } in_item_t;

  typedef struct packed {
    logic [ActBits-1:0] match_count;
    logic               pairs_dropped;
  } out_item_t;

  function automatic logic meets(input cons_t c, input logic [ValueBits-1:0] v);
    logic r;
    case (c.kind)
      KIND_EQ: r = (v == c.low);
      KIND_LE: r = (v <= c.low);
      KIND_GE: r = (v >= c.low);
      default: r = (v >= c.low) && (v <= c.high);
    endcase
    return r;
  endfunction
endpackage

FILE: hdl/smc_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface smc_in_if;
  logic                in_valid;
  logic                in_ready;
  smc_pkg::in_item_t   in_item;
  modport source (output in_valid, output in_item, input in_ready);
  modport sink (input in_valid, input in_item, output in_ready);
endinterface

interface smc_out_if;
  logic                out_valid;
  logic                out_ready;
  smc_pkg::out_item_t  out_item;
  modport source (output out_valid, output out_item, input out_ready);
  modport sink (input out_valid, input out_item, output out_ready);
endinterface

interface smc_cfg_if;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [smc_pkg::ActBits-1:0] cfg_data;
  modport source (output cfg_valid, output cfg_data, input cfg_ready);
  modport sink (input cfg_valid, input cfg_data, output cfg_ready);
endinterface

FILE: hdl/smc_cell.sv
// One pair cell: holds a stored pair and checks the passing constraint against it.
module smc_cell (
  input  logic                            clk,
  input  logic                            load,
  input  logic [smc_pkg::AttrBits-1:0]    load_attr,
  input  logic [smc_pkg::ValueBits-1:0]   load_value,
  input  logic                            used,
  input  smc_pkg::cons_t                  cons_in,
  input  logic                            hit_in,
  output smc_pkg::cons_t                  cons_out,
  output logic                            hit_out
);
  logic [smc_pkg::AttrBits-1:0]  attr_r;
  logic [smc_pkg::ValueBits-1:0] value_r;

  always_ff @(posedge clk) begin
    if (load) begin
      attr_r  <= load_attr;
      value_r <= load_value;
    end
    cons_out <= cons_in;
    hit_out  <= hit_in | (used && attr_r == cons_in.attr && smc_pkg::meets(cons_in, value_r));
  end
endmodule

FILE: hdl/subscription_match_counter.sv
// Top level of the subscription match counter.
// Items arrive on the in_ channel: constraint loads, count writes and publication pairs.
// A load, count or ordinary pair item is taken at once while idle, so such items may follow
// back to back.
// The last pair of a publication starts a sweep of the constraint slots of the active
// subscriptions, eight per subscription and one slot per cycle, through a chain of 16
// pair cells. Each cell holds one stored pair; a constraint gathers a hit as it passes.
// The result item (match_count, pairs_dropped) is offered once the last slot has passed
// the read register, the cell chain and the drain count. The input is not ready from
// the last pair until the result is loaded into the output register.
// The result waits in an output register while further items are taken. If a new
// result is due before the receiver has taken the old one, the sweep holds its result
// and the input stays stalled until the receiver takes the waiting item.
// Configuration writes on cfg_ set active_subs, are always taken and belong between
// publications.
// Reset clears the counts, the pair fill and the control state; the constraint
// store is undefined until loaded.
module subscription_match_counter (
  input logic        clk,
  input logic        rst_n,
  smc_in_if.sink     in_ch,
  smc_out_if.source  out_ch,
  smc_cfg_if.sink    cfg_ch
);
  localparam int NP = smc_pkg::MaxPairs;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  smc_pkg::cons_t cons_mem [smc_pkg::ConsDepth];
  logic [smc_pkg::CntBits-1:0] cnt_r [smc_pkg::MaxSubs];
  logic [smc_pkg::ActBits-1:0] active_r;
  logic [smc_pkg::FillBits-1:0] fill_r;
  logic ovf_r;
  logic [1:0] state_r;
  logic [smc_pkg::ConsBits:0] idx_r;
  logic [$clog2(NP+4)-1:0] drain_r;
  smc_pkg::cons_t rd_r;
  logic rd_valid_r, rd_first_r, rd_lastslot_r, rd_used_r;
  logic [smc_pkg::ActBits-1:0] count_r;
  logic out_valid_r;
  smc_pkg::out_item_t out_r;

  smc_pkg::cons_t chain_c [NP+1];
  logic chain_h [NP+1];
  logic v_pipe [NP+1];
  logic f_pipe [NP+1];
  logic l_pipe [NP+1];
  logic u_pipe [NP+1];
  logic sub_ok_r;

  smc_pkg::in_item_t it;
  logic acc;
  logic [smc_pkg::SubBits-1:0] cur_sub;
  logic [smc_pkg::SlotBits-1:0] cur_slot;
  logic [smc_pkg::ActBits-1:0] limit;
  logic sweep_go;
  logic out_load;

  assign it = in_ch.in_item;
  assign in_ch.in_ready = (state_r == ST_IDLE);
  assign acc = in_ch.in_valid && in_ch.in_ready;
  assign cfg_ch.cfg_ready = 1'b1;
  assign out_ch.out_valid = out_valid_r;
  assign out_ch.out_item = out_r;
  assign cur_sub = idx_r[smc_pkg::ConsBits-1:smc_pkg::SlotBits];
  assign cur_slot = idx_r[smc_pkg::SlotBits-1:0];
  assign limit = (active_r > 7'(smc_pkg::MaxSubs)) ? 7'(smc_pkg::MaxSubs) : active_r;
  assign sweep_go = (state_r == ST_SWEEP) && (idx_r < {limit, {smc_pkg::SlotBits{1'b0}}});
  assign out_load = (state_r == ST_DRAIN) && (drain_r == ($bits(drain_r))'(NP + 3)) &&
                    (!out_valid_r || out_ch.out_ready);

  always_ff @(posedge clk) begin
    if (acc && it.req_type == smc_pkg::REQ_LOAD) begin
      cons_mem[{it.sub_index, it.slot_index}] <= '{it.attribute, it.constraint_kind,
                                                  it.bound_low, it.bound_high};
    end
    rd_r <= cons_mem[idx_r[smc_pkg::ConsBits-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < smc_pkg::MaxSubs; i++) cnt_r[i] <= '0;
    end else if (acc && it.req_type == smc_pkg::REQ_COUNT) begin
      cnt_r[it.sub_index] <= (it.constraint_count > 4'(smc_pkg::MaxCons)) ?
                             4'(smc_pkg::MaxCons) : it.constraint_count;
    end
  end

  assign chain_c[0] = rd_r;
  assign chain_h[0] = 1'b0;
  assign v_pipe[0] = rd_valid_r;
  assign f_pipe[0] = rd_first_r;
  assign l_pipe[0] = rd_lastslot_r;
  assign u_pipe[0] = rd_used_r;

  for (genvar g = 0; g < NP; g++) begin : g_cell
    logic load_g;
    assign load_g = acc && it.req_type == smc_pkg::REQ_PAIR &&
                    fill_r == smc_pkg::FillBits'(g);
    smc_cell u_cell (
      .clk(clk), .load(load_g), .load_attr(it.attribute), .load_value(it.pair_value),
      .used(fill_r > smc_pkg::FillBits'(g)), .cons_in(chain_c[g]), .hit_in(chain_h[g]),
      .cons_out(chain_c[g+1]), .hit_out(chain_h[g+1]));
    always_ff @(posedge clk) begin
      if (!rst_n) v_pipe[g+1] <= 1'b0;
      else v_pipe[g+1] <= v_pipe[g];
      f_pipe[g+1] <= f_pipe[g];
      l_pipe[g+1] <= l_pipe[g];
      u_pipe[g+1] <= u_pipe[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      active_r <= '0;
      fill_r <= '0;
      ovf_r <= 1'b0;
      idx_r <= '0;
      drain_r <= '0;
      rd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r <= '0;
      sub_ok_r <= 1'b1;
    end else begin
      if (cfg_ch.cfg_valid) active_r <= cfg_ch.cfg_data;
      rd_valid_r <= sweep_go;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.out_ready) out_valid_r <= 1'b0;
      if (v_pipe[NP]) begin
        if (l_pipe[NP]) begin
          if ((f_pipe[NP] || sub_ok_r) && (!u_pipe[NP] || chain_h[NP]))
            count_r <= count_r + 1'b1;
          sub_ok_r <= 1'b1;
        end else if (u_pipe[NP] && !chain_h[NP]) begin
          sub_ok_r <= 1'b0;
        end else if (f_pipe[NP]) begin
          sub_ok_r <= 1'b1;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc && it.req_type == smc_pkg::REQ_PAIR) begin
            if (fill_r < smc_pkg::FillBits'(NP)) fill_r <= fill_r + 1'b1;
            else ovf_r <= 1'b1;
            if (it.last_pair) begin
              idx_r <= '0;
              count_r <= '0;
              sub_ok_r <= 1'b1;
              state_r <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (!sweep_go) begin
            drain_r <= '0;
            state_r <= ST_DRAIN;
          end else begin
            rd_first_r <= (cur_slot == '0);
            rd_lastslot_r <= (cur_slot == smc_pkg::SlotBits'(smc_pkg::MaxCons - 1));
            rd_used_r <= {1'b0, cur_slot} < cnt_r[cur_sub];
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            out_r.match_count <= count_r;
            out_r.pairs_dropped <= ovf_r;
            fill_r <= '0;
            ovf_r <= 1'b0;
            state_r <= ST_IDLE;
          end else if (drain_r != ($bits(drain_r))'(NP + 3)) begin
            drain_r <= drain_r + 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: sim/tb.sv
// Self-checking testbench for the subscription match counter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;
  localparam int SweepWait  = 700;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  smc_in_if  in_if ();
  smc_out_if out_if ();
  smc_cfg_if cfg_if ();

  subscription_match_counter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predictor state
  smc_pkg::cons_t                cons_tab [smc_pkg::ConsDepth];
  logic [smc_pkg::CntBits-1:0]   sub_count [smc_pkg::MaxSubs];
  logic [smc_pkg::AttrBits-1:0]  held_attr [smc_pkg::MaxPairs];
  logic [smc_pkg::ValueBits-1:0] held_value [smc_pkg::MaxPairs];
  int                            held_fill;
  logic                          held_overflow;
  logic [smc_pkg::ActBits-1:0]   act_subs;

  smc_pkg::in_item_t  pend_q [$];
  smc_pkg::out_item_t match_q [$];
  int        loaded_prefix [smc_pkg::MaxSubs];
  int        errors;
  int        cycles;
  int        send_gap;
  int        recv_gap;
  int        hold_cycles;
  bit        idle_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic slot_hit(smc_pkg::cons_t c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < held_fill; k++) begin
      if (held_attr[k] == c.attr) begin
        case (c.kind)
          smc_pkg::KIND_EQ: hit |= (held_value[k] == c.low);
          smc_pkg::KIND_LE: hit |= (held_value[k] <= c.low);
          smc_pkg::KIND_GE: hit |= (held_value[k] >= c.low);
          default: hit |= (held_value[k] >= c.low) && (held_value[k] <= c.high);
        endcase
      end
    end
    return hit;
  endfunction

  task automatic predict_item(smc_pkg::in_item_t it);
    int        lim;
    int        matched;
    bit        ok;
    smc_pkg::out_item_t r;
    case (it.req_type)
      smc_pkg::REQ_LOAD: begin
        cons_tab[it.sub_index * smc_pkg::MaxCons + it.slot_index] =
          '{attr: it.attribute, kind: it.constraint_kind,
            low: it.bound_low, high: it.bound_high};
      end
      smc_pkg::REQ_COUNT: begin
        sub_count[it.sub_index] = (it.constraint_count > smc_pkg::MaxCons) ?
                                  smc_pkg::CntBits'(smc_pkg::MaxCons) : it.constraint_count;
      end
      smc_pkg::REQ_PAIR: begin
        if (held_fill < smc_pkg::MaxPairs) begin
          held_attr[held_fill] = it.attribute;
          held_value[held_fill] = it.pair_value;
          held_fill++;
        end else begin
          held_overflow = 1'b1;
        end
        if (it.last_pair) begin
          lim = (act_subs > smc_pkg::MaxSubs) ? smc_pkg::MaxSubs : act_subs;
          matched = 0;
          for (int s = 0; s < lim; s++) begin
            ok = 1'b1;
            for (int j = 0; j < sub_count[s]; j++)
              if (!slot_hit(cons_tab[s * smc_pkg::MaxCons + j])) ok = 1'b0;
            if (ok) matched++;
          end
          r.match_count = smc_pkg::ActBits'(matched);
          r.pairs_dropped = held_overflow;
          match_q.insert(match_q.size(), r);
          held_fill = 0;
          held_overflow = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic smc_pkg::in_item_t noise_item();
    smc_pkg::in_item_t it;
    it.req_type = 2'($urandom_range(0, 3));
    it.sub_index = smc_pkg::SubBits'($urandom);
    it.slot_index = smc_pkg::SlotBits'($urandom);
    it.constraint_count = smc_pkg::CntBits'($urandom);
    it.attribute = smc_pkg::AttrBits'($urandom);
    it.constraint_kind = 2'($urandom);
    it.bound_low = $urandom;
    it.bound_high = $urandom;
    it.pair_value = $urandom;
    it.last_pair = 1'($urandom);
    return it;
  endfunction

  function automatic logic [smc_pkg::ValueBits-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  function automatic logic [smc_pkg::AttrBits-1:0] pick_attr();
    return ($urandom_range(0, 9) == 0) ? smc_pkg::AttrBits'($urandom)
                                       : smc_pkg::AttrBits'($urandom_range(0, 3));
  endfunction

  task automatic add_load(int sub, int slot, logic [smc_pkg::AttrBits-1:0] attr,
                          logic [1:0] kind, logic [smc_pkg::ValueBits-1:0] lo,
                          logic [smc_pkg::ValueBits-1:0] hi);
    smc_pkg::in_item_t it;
    it = noise_item();
    it.req_type = smc_pkg::REQ_LOAD;
    it.sub_index = smc_pkg::SubBits'(sub);
    it.slot_index = smc_pkg::SlotBits'(slot);
    it.attribute = attr;
    it.constraint_kind = kind;
    it.bound_low = lo;
    it.bound_high = hi;
    if (slot == loaded_prefix[sub]) loaded_prefix[sub]++;
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic add_count(int sub, int cnt);
    smc_pkg::in_item_t it;
    it = noise_item();
    it.req_type = smc_pkg::REQ_COUNT;
    it.sub_index = smc_pkg::SubBits'(sub);
    it.constraint_count = smc_pkg::CntBits'(cnt);
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic add_pair(logic [smc_pkg::AttrBits-1:0] attr,
                          logic [smc_pkg::ValueBits-1:0] v, bit last);
    smc_pkg::in_item_t it;
    it = noise_item();
    it.req_type = smc_pkg::REQ_PAIR;
    it.attribute = attr;
    it.pair_value = v;
    it.last_pair = last;
    pend_q.insert(pend_q.size(), it);
  endtask

  task automatic fill_random(int n);
    int k;
    int sub;
    int len;
    int pre;
    smc_pkg::in_item_t it;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 99)) inside
        [0:21]: begin
          sub = $urandom_range(0, smc_pkg::MaxSubs - 1);
          pre = loaded_prefix[sub];
          add_load(sub, (pre < smc_pkg::MaxCons && $urandom_range(0, 9) < 7) ? pre
                        : $urandom_range(0, pre < smc_pkg::MaxCons ? pre
                                                                   : smc_pkg::MaxCons - 1),
                   pick_attr(), 2'($urandom), pick_value(), pick_value());
          k++;
        end
        [22:31]: begin
          sub = $urandom_range(0, smc_pkg::MaxSubs - 1);
          pre = loaded_prefix[sub];
          add_count(sub, (pre == smc_pkg::MaxCons) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, pre));
          k++;
        end
        [32:34]: begin
          it = noise_item();
          it.req_type = REQ_UNUSED;
          pend_q.insert(pend_q.size(), it);
        end
        default: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
          for (int p = 0; p < len; p++)
            add_pair(pick_attr(), pick_value(), (p == len - 1) && ($urandom_range(0, 19) != 0));
          k += len;
        end
      endcase
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pend_q.size() != 0 || in_if.in_valid || match_q.size() != 0);
    repeat (SweepWait) @(posedge clk);
  endtask

  task automatic write_active(logic [smc_pkg::ActBits-1:0] v);
    cfg_if.cfg_valid <= 1'b1;
    cfg_if.cfg_data <= v;
    do @(posedge clk);
    while (!cfg_if.cfg_ready);
    act_subs = v;
    cfg_if.cfg_valid <= 1'b0;
  endtask

  // Item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_if.in_valid || in_if.in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_if.in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        in_if.in_item <= pend_q.pop_front();
        in_if.in_valid <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, 5) : 0;
      end else begin
        in_if.in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.in_valid && in_if.in_ready) predict_item(in_if.in_item);
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    smc_pkg::out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst_n) begin
      out_if.out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_if.out_valid && out_if.out_ready) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_if.out_item);
          errors++;
        end else begin
          want = match_q.pop_front();
          if (out_if.out_item.match_count !== want.match_count) begin
            $display("%0t: match_count expected %0d actual %0d", $time,
                     want.match_count, out_if.out_item.match_count);
            errors++;
          end
          if (out_if.out_item.pairs_dropped !== want.pairs_dropped) begin
            $display("%0t: pairs_dropped expected %0d actual %0d", $time,
                     want.pairs_dropped, out_if.out_item.pairs_dropped);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_if.out_ready <= 1'b0;
      end else if (out_if.out_valid && out_if.out_ready) begin
        recv_gap <= idle_on ? $urandom_range(0, 5) : 0;
        out_if.out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.out_ready <= 1'b0;
      end else begin
        out_if.out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [smc_pkg::ActBits-1:0] phase_act [6];
    rst_n = 1'b0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    idle_on = 1'b1;
    held_fill = 0;
    held_overflow = 1'b0;
    act_subs = '0;
    in_if.in_valid = 1'b0;
    in_if.in_item = '0;
    out_if.out_ready = 1'b0;
    cfg_if.cfg_valid = 1'b0;
    cfg_if.cfg_data = '0;
    for (int s = 0; s < smc_pkg::MaxSubs; s++) begin
      sub_count[s] = '0;
      loaded_prefix[s] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_active(7'd6);
    add_load(0, 0, 8'd0, smc_pkg::KIND_EQ, '0, '1);
    add_load(0, 1, 8'd255, smc_pkg::KIND_LE, '1, '0);
    add_load(1, 0, 8'd5, smc_pkg::KIND_GE, '1, '0);
    add_load(2, 0, 8'd0, smc_pkg::KIND_IN, 32'd20, 32'd10);
    add_load(3, 0, 8'd7, smc_pkg::KIND_IN, 32'd10, 32'd20);
    add_load(5, 0, 8'd7, smc_pkg::KIND_LE, 32'd9, 32'd0);
    add_count(0, 2);
    add_count(1, 1);
    add_count(2, 1);
    add_count(3, 1);
    add_count(4, 0);
    add_count(5, 1);
    add_pair(8'd0, '0, 1'b0);
    add_pair(8'd255, 32'd7, 1'b0);
    add_pair(8'd7, 32'd20, 1'b0);
    add_pair(8'd5, '1, 1'b1);
    add_pair(8'd7, 32'd9, 1'b1);
    begin
      smc_pkg::in_item_t it;
      it = noise_item();
      it.req_type = REQ_UNUSED;
      pend_q.insert(pend_q.size(), it);
    end
    add_pair(8'd0, 32'd15, 1'b1);
    drain();

    phase_act = '{7'd64, 7'd0, 7'd127, 7'd64, 7'($urandom_range(1, 63)), 7'd64};
    for (int ph = 0; ph < 6; ph++) begin
      write_active(phase_act[ph]);
      idle_on = (ph % 3) != 1;
      if (ph == 3) hold_cycles <= 3000;
      fill_random(65);
      if (ph == 2) begin
        do @(posedge clk);
        while (pend_q.size() != 0 || in_if.in_valid || match_q.size() != 0);
      end
      fill_random(65);
      drain();
    end

    if (errors == 0 && match_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/smc_pkg.sv
hdl/smc_if.sv
hdl/smc_cell.sv
hdl/subscription_match_counter.sv
sim/tb.sv
